// ===== sv/gradient_texture_generator_macros.svh =====
// Assertion macros for the gradient texture generator.
// Depends on a clock i_clk and an active-low reset i_rst_n in the including module.
`ifndef GRADIENT_TEXTURE_GENERATOR_MACROS_SVH
`define GRADIENT_TEXTURE_GENERATOR_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define GTG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define GTG_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/gtg_pkg.sv =====
// Shared types, codes and small channel functions for the gradient texture generator.
// No dependencies.
package gtg_pkg;

    localparam int SW = 13;   // side and coordinate width inside the datapath
    localparam int CW = 8;    // color channel width

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_out;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_START  = 3'd2,
        REG_END    = 3'd3,
        REG_MODE   = 3'd4,
        REG_BEVEL  = 3'd5,
        REG_LACE   = 3'd6,
        REG_INVERT = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        MODE_DIAG      = 3'd0,
        MODE_ELLIPTIC  = 3'd1,
        MODE_HORIZ     = 3'd2,
        MODE_PYRAMID   = 3'd3,
        MODE_RECT      = 3'd4,
        MODE_VERT      = 3'd5,
        MODE_CROSSDIAG = 3'd6,
        MODE_PIPECROSS = 3'd7
    } t_mode;

    localparam logic [1:0] BEVEL_OUTER = 2'd1;
    localparam logic [1:0] BEVEL_INSET = 2'd2;

    // Post-processing controls carried down the pipe with each pixel
    typedef struct packed {
        logic [3:0] bev_en;       // frame steps, applied in order 0..3
        logic       bev1_bright;  // step 1 brightens (inset) or darkens (outer)
        logic       lace_en;
        logic       lace_odd;
    } t_finish;

    typedef struct packed {
        t_finish fin;
        logic    use_x;           // shaped modes: take the x ramp
    } t_side;

    function automatic logic [CW-1:0] brighten(input logic [CW-1:0] c);
        logic [CW:0] v;
        v = {1'b0, c} + {4'b0, c[7:3]};
        return v[CW] ? {CW{1'b1}} : v[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] darken(input logic [CW-1:0] c);
        logic [CW+1:0] v;
        v = {1'b0, c, 1'b0} + {2'b0, c};
        return v[CW+1:2];
    endfunction

endpackage

// ===== sv/gradient_texture_generator.sv =====
// Gradient texture generator: one pixel coordinate in, one RGB pixel out.
// Each pixel passes register stages 1 to 4, the divider stages and post stages 1 to
// 3, whose last register drives o_pix; o_valid comes from a valid shift line of matching depth.
// Throughput one pixel per clock; busy stays low, the pipe never stalls.
// The depth is set by the 8-stage pipelined dividers for the ramps and ellipse.
// Synchronous reset clears the pipe valid bits and restores register defaults.
// Depends on gtg_pkg, gtg_div and gradient_texture_generator_macros.svh.
`include "gradient_texture_generator_macros.svh"
module gradient_texture_generator #(
    parameter int MAX_SIDE = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [23:0]       i_cfg_data,
    input  logic              start,
    output logic              busy,
    input  gtg_pkg::t_pix_in  i_pix,
    output logic              o_valid,
    output gtg_pkg::t_pix_out o_pix
);
    import gtg_pkg::*;

    localparam int SideCap  = (MAX_SIDE > 8191) ? 8191 : MAX_SIDE;
    localparam int PIPE_LAT = 15;
    localparam int NRW      = SW + CW;       // ramp numerator width
    localparam int SQW      = 2 * SW;        // squared side width
    localparam int DLY      = 8;             // divider depth

    // ---------------- configuration registers ----------------
    logic [SW-1:0] r_width, r_height;
    logic [23:0]   r_start_color, r_end_color;
    t_mode         r_mode;
    logic [1:0]    r_bevel;
    logic          r_lace, r_invert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width       <= SW'(64);
            r_height      <= SW'(64);
            r_start_color <= 24'h000000;
            r_end_color   <= 24'hFFFFFF;
            r_mode        <= MODE_HORIZ;
            r_bevel       <= 2'd0;
            r_lace        <= 1'b0;
            r_invert      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_WIDTH:  r_width       <= i_cfg_data[SW-1:0];
                REG_HEIGHT: r_height      <= i_cfg_data[SW-1:0];
                REG_START:  r_start_color <= i_cfg_data;
                REG_END:    r_end_color   <= i_cfg_data;
                REG_MODE:   r_mode        <= t_mode'(i_cfg_data[2:0]);
                REG_BEVEL:  r_bevel       <= i_cfg_data[1:0];
                REG_LACE:   r_lace        <= i_cfg_data[0];
                REG_INVERT: r_invert      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- derived sizes and per-channel colors ----------------
    logic [SW-1:0] w_w, w_h, w_wm1, w_hm1, w_halfw, w_halfh;
    logic          w_mir, w_rev;
    logic [CW-1:0] w_f [3], w_t [3], w_fx [3], w_tx [3], w_ex [3], w_ey [3];
    logic          w_negx [3], w_negy [3];

    always_comb begin
        w_w = (r_width == '0) ? SW'(1) :
              (int'(r_width) > SideCap) ? SW'(SideCap) : r_width;
        w_h = (r_height == '0) ? SW'(1) :
              (int'(r_height) > SideCap) ? SW'(SideCap) : r_height;
        w_wm1   = w_w - SW'(1);
        w_hm1   = w_h - SW'(1);
        w_halfw = (w_w >> 1) + SW'(w_w[0]);
        w_halfh = (w_h >> 1) + SW'(w_h[0]);
        w_mir   = (r_mode == MODE_PYRAMID) || (r_mode == MODE_RECT) ||
                  (r_mode == MODE_PIPECROSS);
        w_rev   = (r_mode == MODE_CROSSDIAG);
        for (int k = 0; k < 3; k++) begin
            w_f[k]    = r_start_color[8*(2-k) +: 8];
            w_t[k]    = r_end_color[8*(2-k) +: 8];
            w_fx[k]   = w_rev ? w_t[k] : w_f[k];
            w_tx[k]   = w_rev ? w_f[k] : w_t[k];
            w_negx[k] = w_tx[k] < w_fx[k];
            w_ex[k]   = w_negx[k] ? (w_fx[k] - w_tx[k]) : (w_tx[k] - w_fx[k]);
            w_negy[k] = w_t[k] < w_f[k];
            w_ey[k]   = w_negy[k] ? (w_f[k] - w_t[k]) : (w_t[k] - w_f[k]);
        end
    end

    // ---------------- valid shift line ----------------
    logic                w_acc;
    logic [PIPE_LAT-1:0] r_vld;

    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-2:0], w_acc};
        end
    end

    // ---------------- stage 1: clamp and mirror coordinates ----------------
    logic [SW-1:0] n1_x, n1_y, w_cx, w_cy;
    logic [SW-1:0] r1_x, r1_y;

    always_comb begin
        w_cx = ({1'b0, i_pix.pixel_x} > w_wm1) ? w_wm1 : {1'b0, i_pix.pixel_x};
        w_cy = ({1'b0, i_pix.pixel_y} > w_hm1) ? w_hm1 : {1'b0, i_pix.pixel_y};
        n1_x = r_invert ? (w_wm1 - w_cx) : w_cx;
        n1_y = r_invert ? (w_hm1 - w_cy) : w_cy;
    end

    always_ff @(posedge i_clk) begin
        r1_x <= n1_x;
        r1_y <= n1_y;
    end

    // ---------------- stage 2: ramp indexes, ellipse offsets, frame flags ----------------
    logic [SW-1:0] n2_mx, n2_my, n2_nx, n2_ny, n2_adx, n2_ady;
    logic [SW:0]   w_2x, w_2y;
    t_finish       n2_fin;
    logic          w_outer, w_inset;
    logic [SW-1:0] r2_x, r2_y, r2_mx, r2_my, r2_nx, r2_ny, r2_adx, r2_ady;
    t_finish       r2_fin;

    always_comb begin
        n2_nx = w_mir ? w_halfw : w_w;
        n2_ny = w_mir ? w_halfh : w_h;
        n2_mx = (w_mir && (r1_x >= w_halfw)) ? (w_wm1 - r1_x) : r1_x;
        n2_my = (w_mir && (r1_y >= w_halfh)) ? (w_hm1 - r1_y) : r1_y;
        // |2x - W| and |2y - H|
        w_2x   = {r1_x, 1'b0};
        w_2y   = {r1_y, 1'b0};
        n2_adx = (w_2x >= {1'b0, w_w}) ? SW'(w_2x - {1'b0, w_w}) : SW'({1'b0, w_w} - w_2x);
        n2_ady = (w_2y >= {1'b0, w_h}) ? SW'(w_2y - {1'b0, w_h}) : SW'({1'b0, w_h} - w_2y);

        w_outer = (r_bevel == BEVEL_OUTER) && (w_w > SW'(2)) && (w_h > SW'(2));
        w_inset = (r_bevel == BEVEL_INSET) && (w_w > SW'(4)) && (w_h > SW'(4));
        n2_fin.lace_en     = r_lace;
        n2_fin.lace_odd    = r1_y[0];
        n2_fin.bev1_bright = w_inset;
        if (w_outer) begin
            n2_fin.bev_en[0] = (r1_y == '0) || (r1_x == '0);
            n2_fin.bev_en[1] = (r1_x == w_wm1) && (r1_y != '0) && (r1_y < w_hm1);
            n2_fin.bev_en[2] = (r1_y == w_hm1) && (r1_x != '0);
            n2_fin.bev_en[3] = (r1_y == w_hm1) && ((r1_x == w_wm1) || (r1_x == '0));
        end else if (w_inset) begin
            n2_fin.bev_en[0] = (r1_y == SW'(1)) && (r1_x != '0) && (r1_x <= w_w - SW'(3));
            n2_fin.bev_en[1] = (r1_x == SW'(1)) && (r1_y >= SW'(2)) && (r1_y <= w_h - SW'(2));
            n2_fin.bev_en[2] = (r1_x == w_w - SW'(2)) && (r1_y != '0) &&
                               (r1_y <= w_h - SW'(3));
            n2_fin.bev_en[3] = (r1_y == w_h - SW'(2)) && (r1_x >= SW'(2)) &&
                               (r1_x <= w_w - SW'(2));
        end else begin
            n2_fin.bev_en = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_x   <= r1_x;
        r2_y   <= r1_y;
        r2_mx  <= n2_mx;
        r2_my  <= n2_my;
        r2_nx  <= n2_nx;
        r2_ny  <= n2_ny;
        r2_adx <= n2_adx;
        r2_ady <= n2_ady;
        r2_fin <= n2_fin;
    end

    // ---------------- stage 3: products ----------------
    logic [NRW-1:0] r3_px [3], r3_py [3];
    logic [SQW-1:0] r3_pa, r3_pb, r3_pc, r3_sqx, r3_sqy, r3_ww, r3_hh;
    logic [SW-1:0]  r3_nx, r3_ny;
    t_finish        r3_fin;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r3_px[k] <= NRW'(r2_mx) * NRW'(w_ex[k]);
            r3_py[k] <= NRW'(r2_my) * NRW'(w_ey[k]);
        end
        // corner-diagonal cross products
        r3_pa  <= SQW'(w_wm1) * SQW'(r2_y);
        r3_pb  <= SQW'(w_hm1) * SQW'(r2_x);
        r3_pc  <= SQW'(w_wm1) * SQW'(w_hm1 - r2_y);
        r3_sqx <= SQW'(r2_adx) * SQW'(r2_adx);
        r3_sqy <= SQW'(r2_ady) * SQW'(r2_ady);
        r3_ww  <= SQW'(w_w) * SQW'(w_w);
        r3_hh  <= SQW'(w_h) * SQW'(w_h);
        r3_nx  <= r2_nx;
        r3_ny  <= r2_ny;
        r3_fin <= r2_fin;
    end

    // ---------------- stage 4: divider operands and shape select ----------------
    logic [NRW-1:0]    r4_numx [3], r4_numy [3];
    logic [SW-1:0]     r4_nx, r4_ny;
    logic [SQW+15:0]   r4_numex, r4_numey;
    logic [SQW-1:0]    r4_ww, r4_hh;
    t_side             n4_side, r4_side;
    logic              w_selpos, w_selneg;

    always_comb begin
        // c1 = pa - pb, c2 = pb - pc; sign of their product
        w_selpos = ((r3_pa > r3_pb) && (r3_pb > r3_pc)) ||
                   ((r3_pa < r3_pb) && (r3_pb < r3_pc));
        w_selneg = ((r3_pa > r3_pb) && (r3_pb < r3_pc)) ||
                   ((r3_pa < r3_pb) && (r3_pb > r3_pc));
        n4_side.fin   = r3_fin;
        n4_side.use_x = (r_mode == MODE_RECT) ? w_selneg : w_selpos;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            // falling ramp: round the magnitude up so F - q is the floor
            r4_numx[k] <= w_negx[k] ? (r3_px[k] + NRW'(r3_nx) - NRW'(1)) : r3_px[k];
            r4_numy[k] <= w_negy[k] ? (r3_py[k] + NRW'(r3_ny) - NRW'(1)) : r3_py[k];
        end
        r4_nx    <= r3_nx;
        r4_ny    <= r3_ny;
        r4_numex <= {1'b0, r3_sqx, 15'b0};
        r4_numey <= {1'b0, r3_sqy, 15'b0};
        r4_ww    <= r3_ww;
        r4_hh    <= r3_hh;
        r4_side  <= n4_side;
    end

    // ---------------- dividers ----------------
    logic [CW-1:0] w_qx [3], w_qy [3];
    logic [15:0]   w_qex, w_qey;

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_chan_div
            gtg_div #(.DW(SW), .QW(CW), .BPS(1)) u_div_x (
                .i_clk (i_clk),
                .i_num (r4_numx[g]),
                .i_den (r4_nx),
                .o_quo (w_qx[g])
            );
            gtg_div #(.DW(SW), .QW(CW), .BPS(1)) u_div_y (
                .i_clk (i_clk),
                .i_num (r4_numy[g]),
                .i_den (r4_ny),
                .o_quo (w_qy[g])
            );
        end
    endgenerate

    gtg_div #(.DW(SQW), .QW(16), .BPS(2)) u_div_ex (
        .i_clk (i_clk),
        .i_num (r4_numex),
        .i_den (r4_ww),
        .o_quo (w_qex)
    );

    gtg_div #(.DW(SQW), .QW(16), .BPS(2)) u_div_ey (
        .i_clk (i_clk),
        .i_num (r4_numey),
        .i_den (r4_hh),
        .o_quo (w_qey)
    );

    // side information rides alongside the dividers
    t_side r_sd [DLY];

    always_ff @(posedge i_clk) begin
        r_sd[0] <= r4_side;
        for (int i = 1; i < DLY; i++) begin
            r_sd[i] <= r_sd[i-1];
        end
    end

    // ---------------- post 1: ramp values, ellipse product ----------------
    logic [CW-1:0]      w_rx [3], w_ry [3], n13_ramp [3];
    logic [16:0]        w_d;
    logic signed [26:0] r13_eprod [3];
    logic [CW-1:0]      r13_ramp [3];
    t_finish            r13_fin;

    always_comb begin
        w_d = {1'b0, w_qex} + {1'b0, w_qey};
        for (int k = 0; k < 3; k++) begin
            w_rx[k] = w_negx[k] ? (w_fx[k] - w_qx[k]) : (w_fx[k] + w_qx[k]);
            w_ry[k] = w_negy[k] ? (w_f[k] - w_qy[k]) : (w_f[k] + w_qy[k]);
            case (r_mode) inside
                MODE_DIAG, MODE_PYRAMID, MODE_CROSSDIAG:
                    n13_ramp[k] = (w_rx[k] >> 1) + (w_ry[k] >> 1);
                MODE_HORIZ:
                    n13_ramp[k] = w_rx[k];
                MODE_VERT:
                    n13_ramp[k] = w_ry[k];
                default:
                    n13_ramp[k] = r_sd[DLY-1].use_x ? w_rx[k] : w_ry[k];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r13_ramp[k]  <= n13_ramp[k];
            r13_eprod[k] <= 27'($signed({1'b0, w_d}) *
                                $signed({1'b0, w_t[k]} - {1'b0, w_f[k]}));
        end
        r13_fin <= r_sd[DLY-1].fin;
    end

    // ---------------- post 2: ellipse clamp, interlace ----------------
    logic signed [26:0] w_ev [3];
    logic [CW-1:0]      w_cv [3], n14_v [3];
    logic [CW-1:0]      r14_v [3];
    t_finish            r14_fin;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_ev[k] = $signed({3'b0, w_t[k], 16'b0}) - r13_eprod[k];
            if (w_ev[k] < 0) begin
                w_cv[k] = '0;
            end else if (w_ev[k][26:24] != 3'b0) begin
                w_cv[k] = {CW{1'b1}};
            end else begin
                w_cv[k] = w_ev[k][23:16];
            end
            n14_v[k] = (r_mode == MODE_ELLIPTIC) ? w_cv[k] : r13_ramp[k];
            if (r13_fin.lace_en) begin
                n14_v[k] = r13_fin.lace_odd ? darken(n14_v[k]) : brighten(n14_v[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r14_v[k] <= n14_v[k];
        end
        r14_fin <= r13_fin;
    end

    // ---------------- post 3: bevel frame, output register ----------------
    logic [CW-1:0] n15_v [3];
    t_pix_out      r_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n15_v[k] = r14_v[k];
            if (r14_fin.bev_en[0]) n15_v[k] = brighten(n15_v[k]);
            if (r14_fin.bev_en[1]) begin
                n15_v[k] = r14_fin.bev1_bright ? brighten(n15_v[k]) : darken(n15_v[k]);
            end
            if (r14_fin.bev_en[2]) n15_v[k] = darken(n15_v[k]);
            if (r14_fin.bev_en[3]) n15_v[k] = darken(n15_v[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.red   <= n15_v[0];
        r_out.green <= n15_v[1];
        r_out.blue  <= n15_v[2];
    end

    assign o_pix   = r_out;
    assign o_valid = r_vld[PIPE_LAT-1];

    // ---------------- assertions ----------------
    logic w_ellip_big;

    // either ellipse term above one half
    assign w_ellip_big = (w_qex > 16'h8000) || (w_qey > 16'h8000);

    `GTG_ASSERT(a_latency, (start && !busy) |-> ##PIPE_LAT o_valid, "result strobe missing")
    `GTG_ASSERT(a_mirror_idx, r_vld[1] |-> (r2_mx < r2_nx), "ramp index past ramp length")
    `GTG_ASSERT_NEVER(a_ellip_quo, r_vld[11] && w_ellip_big, "ellipse term overflow")

endmodule

// ===== sv/gtg_div.sv =====
// Pipelined restoring divider, BPS quotient bits per register stage.
// Caller guarantees the quotient fits QW bits. No package dependency.
module gtg_div #(
    parameter int DW  = 13,
    parameter int QW  = 8,
    parameter int BPS = 1
) (
    input  logic               i_clk,
    input  logic [DW+QW-1:0]   i_num,
    input  logic [DW-1:0]      i_den,
    output logic [QW-1:0]      o_quo
);
    localparam int NS = QW / BPS;
    localparam int RW = DW + QW;

    logic [RW-1:0] r_rem [NS];
    logic [DW-1:0] r_den [NS];
    logic [QW-1:0] r_quo [NS];

    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_stage
            logic [RW-1:0] w_rem_in;
            logic [DW-1:0] w_den_in;
            logic [QW-1:0] w_quo_in;
            logic [RW-1:0] n_rem;
            logic [QW-1:0] n_quo;

            if (s == 0) begin : g_first
                assign w_rem_in = i_num;
                assign w_den_in = i_den;
                assign w_quo_in = '0;
            end else begin : g_next
                assign w_rem_in = r_rem[s-1];
                assign w_den_in = r_den[s-1];
                assign w_quo_in = r_quo[s-1];
            end

            // trial subtract of the shifted divisor, MSB first
            always_comb begin
                n_rem = w_rem_in;
                n_quo = w_quo_in;
                for (int b = 0; b < BPS; b++) begin
                    if (n_rem >= (RW'(w_den_in) << (QW - 1 - (s * BPS + b)))) begin
                        n_rem = n_rem - (RW'(w_den_in) << (QW - 1 - (s * BPS + b)));
                        n_quo[QW - 1 - (s * BPS + b)] = 1'b1;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[s] <= n_rem;
                r_den[s] <= w_den_in;
                r_quo[s] <= n_quo;
            end
        end
    endgenerate

    assign o_quo = r_quo[NS-1];

endmodule
